/* design/fpss_pkg.sv */
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared types, codes and helpers of the fixed-point stack script core.
// ----------------------------------------------------------------------------
package fpss_pkg;

  localparam int unsigned FRAME_AW  = 10;
  localparam int unsigned GLOBAL_AW = 9;
  localparam int unsigned RET_AW    = 6;
  localparam int unsigned LINE_W    = 12;
  localparam int unsigned DIV_STEPS = 40;

  typedef enum logic [7:0] {
    OP_BASE_ADD  = 8'd2,
    OP_STACK_ADD = 8'd3,
    OP_SET_B     = 8'd10,
    OP_SET_S     = 8'd11,
    OP_MOV_BI    = 8'd12,
    OP_MOV_SB    = 8'd13,
    OP_MOV_SS    = 8'd14,
    OP_GSET      = 8'd20,
    OP_GMOV_I    = 8'd21,
    OP_GLOAD     = 8'd22,
    OP_GSTORE    = 8'd23,
    OP_ADDC      = 8'd30,
    OP_ADD       = 8'd40,
    OP_MUL       = 8'd41,
    OP_SUB       = 8'd42,
    OP_DIV       = 8'd43,
    OP_GLOAD_I   = 8'd44,
    OP_LOAD_BI   = 8'd45,
    OP_AND       = 8'd46,
    OP_JZ        = 8'd50,
    OP_JNZ       = 8'd51,
    OP_JMP       = 8'd52,
    OP_EQ        = 8'd60,
    OP_NE        = 8'd61,
    OP_GT        = 8'd62,
    OP_GE        = 8'd63,
    OP_LOR       = 8'd64,
    OP_LAND      = 8'd65,
    OP_CALL      = 8'd70,
    OP_RET       = 8'd71,
    OP_EXT       = 8'd100
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_RUN  = 2'd0,
    STAT_DONE = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_DIV0 = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RDX   = 8'b0000_0100,
    S_RDY   = 8'b0000_1000,
    S_RDZ   = 8'b0001_0000,
    S_EXEC  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  localparam logic [31:0] FX_ONE = 32'd256;

  function automatic logic signed [23:0] div256(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + (v[31] ? 32'sd255 : 32'sd0);
    return t[31:8];
  endfunction

endpackage

/* design/fpss_if.sv */
// ----------------------------------------------------------------------------
// fpss_if
// Instruction and result channels of the fixed-point stack script core.
// ----------------------------------------------------------------------------
interface fpss_in_if #(
  parameter int unsigned LINE_W = fpss_pkg::LINE_W
);
  logic                valid;
  logic                ready;
  logic                action;
  logic [LINE_W-1:0]   start_line;
  logic [7:0]          opcode;
  logic signed [31:0]  arg_one;
  logic signed [31:0]  arg_two;
  logic signed [31:0]  ext_value;

  modport source (output valid, action, start_line, opcode, arg_one, arg_two, ext_value,
                  input ready);
  modport sink (input valid, action, start_line, opcode, arg_one, arg_two, ext_value,
                output ready);
endinterface

interface fpss_out_if #(
  parameter int unsigned LINE_W = fpss_pkg::LINE_W
);
  logic                valid;
  logic                ready;
  logic [LINE_W-1:0]   next_line;
  logic [1:0]          status;
  logic                ext_request;
  logic signed [23:0]  ext_id;

  modport source (output valid, next_line, status, ext_request, ext_id, input ready);
  modport sink (input valid, next_line, status, ext_request, ext_id, output ready);
endinterface

/* design/fixed_point_stack_script_core.sv */
// ----------------------------------------------------------------------------
// fixed_point_stack_script_core
// Executes one bytecode instruction of a stack machine per beat.
// ----------------------------------------------------------------------------
// Each beat on in_i either starts a routine or executes one instruction, and
// yields exactly one beat on out_o with the next line to fetch and a status.
// The frame, global and return stores are synchronous memories with one read and one write port each.
// An instruction reads the frame store three times in sequence, then executes
// and writes back; a divide instead runs its 40 quotient bits through a
// one-bit-per-cycle divider before it writes back.
// Start beats and beats taken while halted skip the reads and go straight to completion.
// The next beat is accepted as soon as the core is back in its idle state,
// while a result may still wait in the output register. A stalled receiver
// holds the finished result in place and keeps the core from completing the
// next instruction until the register is free.
// After reset the core sweeps zeros through the frame and global stores, one
// entry per cycle, for the larger of the two depths, before it accepts its first
// beat. It comes out of reset halted.
// ----------------------------------------------------------------------------
module fixed_point_stack_script_core #(
  parameter int unsigned FRAME_AW  = fpss_pkg::FRAME_AW,
  parameter int unsigned GLOBAL_AW = fpss_pkg::GLOBAL_AW,
  parameter int unsigned RET_AW    = fpss_pkg::RET_AW,
  parameter int unsigned LINE_W    = fpss_pkg::LINE_W
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpss_in_if.sink   in_i,
  fpss_out_if.source out_o
);

  localparam int unsigned FDEPTH = 1 << FRAME_AW;
  localparam int unsigned GDEPTH = 1 << GLOBAL_AW;
  localparam int unsigned RDEPTH = 1 << RET_AW;
  localparam int unsigned MAXAW  = (FRAME_AW > GLOBAL_AW) ? FRAME_AW : GLOBAL_AW;
  localparam int unsigned CNT_W  = $clog2(fpss_pkg::DIV_STEPS);

  fpss_pkg::state_e state_q, state_d;

  logic [31:0] frame_mem [FDEPTH];
  logic [31:0] glob_mem  [GDEPTH];
  logic [LINE_W-1:0] ret_mem [RDEPTH];

  logic [31:0] fr_rd_q, gl_rd_q;
  logic [LINE_W-1:0] ret_rd_q;
  logic [FRAME_AW-1:0] fr_ra, fr_wa;
  logic [GLOBAL_AW-1:0] gl_ra, gl_wa;
  logic [RET_AW-1:0] ret_ra, ret_wa;
  logic [31:0] fr_wd, gl_wd;
  logic [LINE_W-1:0] ret_wd;
  logic fr_we, gl_we, ret_we;

  logic [MAXAW-1:0] clr_q;

  logic [7:0] op_q;
  logic signed [31:0] a2_q, ext_q;
  logic signed [23:0] o1_q, o2_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [63:0] prod_q;

  logic [FRAME_AW-1:0] base_q, sp_q, base_d, sp_d;
  logic [LINE_W-1:0] ip_q, ip_d;
  logic [RET_AW:0] depth_q, depth_d;
  logic halted_q, halted_d;
  logic commit;

  logic [LINE_W-1:0] res_line_q;
  logic [1:0] res_stat_q, res_stat_d;
  logic res_ereq_q, res_ereq_d;
  logic signed [23:0] res_eid_q, res_eid_d;

  logic out_valid_q;
  logic [LINE_W-1:0] out_line_q;
  logic [1:0] out_stat_q;
  logic out_ereq_q;
  logic signed [23:0] out_eid_q;

  logic [39:0] num_q;
  logic [31:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic sign_q, go_div;
  logic [32:0] div_sh, div_sub;
  logic div_bit;
  logic [39:0] div_q, div_res;

  logic signed [23:0] in_o1, rd_off, x_off;
  logic signed [63:0] prod_adj;
  logic [31:0] abs_x, abs_y;
  logic accept, out_free;
  logic [FRAME_AW-1:0] fs1, fs2;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == fpss_pkg::S_IDLE);

  assign in_o1  = fpss_pkg::div256(in_i.arg_one);
  assign rd_off = fpss_pkg::div256(fr_rd_q);
  assign x_off  = fpss_pkg::div256(x_q);
  assign fs1    = sp_q + o1_q[FRAME_AW-1:0];
  assign fs2    = sp_q + o2_q[FRAME_AW-1:0];
  assign ret_ra = RET_AW'(depth_q - 1'b1);

  assign prod_adj = prod_q + (prod_q[63] ? 64'sd255 : 64'sd0);
  assign abs_x = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign abs_y = y_q[31] ? (~y_q + 32'd1) : y_q;

  assign div_sh  = {rem_q, num_q[39]};
  assign div_sub = div_sh - {1'b0, den_q};
  assign div_bit = !div_sub[32];
  assign div_q   = {num_q[38:0], div_bit};
  assign div_res = sign_q ? (~div_q + 40'd1) : div_q;

  always_comb begin
    case (state_q)
      fpss_pkg::S_IDLE: fr_ra = sp_q + in_o1[FRAME_AW-1:0];
      fpss_pkg::S_RDX:  fr_ra = fs2;
      fpss_pkg::S_RDY: begin
        case (op_q)
          fpss_pkg::OP_MOV_SB:  fr_ra = base_q + o2_q[FRAME_AW-1:0];
          fpss_pkg::OP_LOAD_BI: fr_ra = base_q + rd_off[FRAME_AW-1:0];
          default:              fr_ra = sp_q;
        endcase
      end
      default: fr_ra = fs1;
    endcase
    gl_ra = (op_q == fpss_pkg::OP_GLOAD_I) ? rd_off[GLOBAL_AW-1:0] : o2_q[GLOBAL_AW-1:0];
  end

  always_comb begin
    state_d    = state_q;
    fr_we      = 1'b0;
    fr_wa      = fs1;
    fr_wd      = 32'd0;
    gl_we      = 1'b0;
    gl_wa      = o1_q[GLOBAL_AW-1:0];
    gl_wd      = y_q;
    ret_we     = 1'b0;
    ret_wa     = depth_q[RET_AW-1:0];
    ret_wd     = ip_q;
    base_d     = base_q;
    sp_d       = sp_q;
    ip_d       = ip_q + 1'b1;
    depth_d    = depth_q;
    halted_d   = halted_q;
    commit     = 1'b0;
    go_div     = 1'b0;
    res_stat_d = fpss_pkg::STAT_RUN;
    res_ereq_d = 1'b0;
    res_eid_d  = 24'sd0;
    case (state_q)
      fpss_pkg::S_CLEAR: begin
        fr_we = ({1'b0, clr_q} < (MAXAW+1)'(FDEPTH));
        gl_we = ({1'b0, clr_q} < (MAXAW+1)'(GDEPTH));
        fr_wa = clr_q[FRAME_AW-1:0];
        gl_wa = clr_q[GLOBAL_AW-1:0];
        gl_wd = 32'd0;
        if (clr_q == MAXAW'((1 << MAXAW) - 1)) begin
          state_d = fpss_pkg::S_IDLE;
        end
      end
      fpss_pkg::S_IDLE: begin
        if (accept) begin
          if (!in_i.action) begin
            commit   = 1'b1;
            base_d   = FRAME_AW'(1);
            sp_d     = FRAME_AW'(1);
            depth_d  = '0;
            halted_d = 1'b0;
            ip_d     = in_i.start_line;
            state_d  = fpss_pkg::S_FIN;
          end else if (halted_q) begin
            commit     = 1'b1;
            ip_d       = ip_q;
            res_stat_d = fpss_pkg::STAT_DONE;
            state_d    = fpss_pkg::S_FIN;
          end else begin
            state_d = fpss_pkg::S_RDX;
          end
        end
      end
      fpss_pkg::S_RDX: state_d = fpss_pkg::S_RDY;
      fpss_pkg::S_RDY: state_d = fpss_pkg::S_RDZ;
      fpss_pkg::S_RDZ: state_d = fpss_pkg::S_EXEC;
      fpss_pkg::S_EXEC: begin
        commit  = 1'b1;
        state_d = fpss_pkg::S_FIN;
        case (op_q)
          fpss_pkg::OP_BASE_ADD:  base_d = base_q + o1_q[FRAME_AW-1:0];
          fpss_pkg::OP_STACK_ADD: sp_d = sp_q + o1_q[FRAME_AW-1:0];
          fpss_pkg::OP_SET_B: begin
            fr_we = 1'b1;
            fr_wa = base_q + o1_q[FRAME_AW-1:0];
            fr_wd = a2_q;
          end
          fpss_pkg::OP_SET_S: begin
            fr_we = 1'b1;
            fr_wd = a2_q;
          end
          fpss_pkg::OP_MOV_BI: begin
            fr_we = 1'b1;
            fr_wa = base_q + x_off[FRAME_AW-1:0];
            fr_wd = y_q;
          end
          fpss_pkg::OP_MOV_SB, fpss_pkg::OP_GLOAD, fpss_pkg::OP_GLOAD_I,
          fpss_pkg::OP_LOAD_BI: begin
            fr_we = 1'b1;
            fr_wd = z_q;
          end
          fpss_pkg::OP_MOV_SS: begin
            fr_we = 1'b1;
            fr_wd = y_q;
          end
          fpss_pkg::OP_GSET: begin
            gl_we = 1'b1;
            gl_wd = a2_q;
          end
          fpss_pkg::OP_GMOV_I: begin
            gl_we = 1'b1;
            gl_wa = x_off[GLOBAL_AW-1:0];
          end
          fpss_pkg::OP_GSTORE: gl_we = 1'b1;
          fpss_pkg::OP_ADDC: begin
            fr_we = 1'b1;
            fr_wd = x_q + a2_q;
          end
          fpss_pkg::OP_ADD: begin
            fr_we = 1'b1;
            fr_wd = x_q + y_q;
          end
          fpss_pkg::OP_MUL: begin
            fr_we = 1'b1;
            fr_wd = prod_adj[39:8];
          end
          fpss_pkg::OP_SUB: begin
            fr_we = 1'b1;
            fr_wd = x_q - y_q;
          end
          fpss_pkg::OP_DIV: begin
            if (y_q == 32'sd0) begin
              halted_d   = 1'b1;
              res_stat_d = fpss_pkg::STAT_DIV0;
            end else begin
              go_div  = 1'b1;
              state_d = fpss_pkg::S_DIV;
            end
          end
          fpss_pkg::OP_AND: begin
            fr_we = 1'b1;
            fr_wd = x_q & y_q;
          end
          fpss_pkg::OP_JZ: begin
            if (z_q == 32'sd0) begin
              ip_d = o1_q[LINE_W-1:0] + 1'b1;
            end
          end
          fpss_pkg::OP_JNZ: begin
            if (z_q != 32'sd0) begin
              ip_d = o1_q[LINE_W-1:0] + 1'b1;
            end
          end
          fpss_pkg::OP_JMP: ip_d = o1_q[LINE_W-1:0] + 1'b1;
          fpss_pkg::OP_EQ: begin
            fr_we = 1'b1;
            fr_wd = (x_q == y_q) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_NE: begin
            fr_we = 1'b1;
            fr_wd = (x_q != y_q) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_GT: begin
            fr_we = 1'b1;
            fr_wd = (x_q > y_q) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_GE: begin
            fr_we = 1'b1;
            fr_wd = (x_q >= y_q) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_LOR: begin
            fr_we = 1'b1;
            fr_wd = (x_q != 32'sd0 || y_q != 32'sd0) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_LAND: begin
            fr_we = 1'b1;
            fr_wd = (x_q != 32'sd0 && y_q != 32'sd0) ? fpss_pkg::FX_ONE : 32'd0;
          end
          fpss_pkg::OP_CALL: begin
            if (depth_q < (RET_AW+1)'(RDEPTH)) begin
              ret_we  = 1'b1;
              depth_d = depth_q + 1'b1;
            end
            ip_d = o1_q[LINE_W-1:0] + 1'b1;
          end
          fpss_pkg::OP_RET: begin
            if (depth_q == '0) begin
              halted_d   = 1'b1;
              res_stat_d = fpss_pkg::STAT_DONE;
            end else begin
              depth_d = depth_q - 1'b1;
              ip_d    = ret_rd_q + 1'b1;
            end
          end
          fpss_pkg::OP_EXT: begin
            fr_we      = 1'b1;
            fr_wa      = base_q - 1'b1;
            fr_wd      = ext_q;
            res_ereq_d = 1'b1;
            res_eid_d  = o1_q;
          end
          default: begin
            halted_d   = 1'b1;
            res_stat_d = fpss_pkg::STAT_BAD;
          end
        endcase
      end
      fpss_pkg::S_DIV: begin
        if (cnt_q == CNT_W'(fpss_pkg::DIV_STEPS - 1)) begin
          fr_we   = 1'b1;
          fr_wd   = div_res[31:0];
          state_d = fpss_pkg::S_FIN;
        end
      end
      fpss_pkg::S_FIN: begin
        if (out_free) begin
          state_d = fpss_pkg::S_IDLE;
        end
      end
      default: state_d = fpss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_wa] <= fr_wd;
    end
    fr_rd_q <= frame_mem[fr_ra];
    if (gl_we) begin
      glob_mem[gl_wa] <= gl_wd;
    end
    gl_rd_q <= glob_mem[gl_ra];
    if (ret_we) begin
      ret_mem[ret_wa] <= ret_wd;
    end
    ret_rd_q <= ret_mem[ret_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.opcode;
      a2_q  <= in_i.arg_two;
      ext_q <= in_i.ext_value;
      o1_q  <= in_o1;
      o2_q  <= fpss_pkg::div256(in_i.arg_two);
    end
    if (state_q == fpss_pkg::S_RDX) begin
      x_q <= fr_rd_q;
    end
    if (state_q == fpss_pkg::S_RDY) begin
      y_q <= fr_rd_q;
    end
    if (state_q == fpss_pkg::S_RDZ) begin
      z_q    <= (op_q == fpss_pkg::OP_GLOAD || op_q == fpss_pkg::OP_GLOAD_I) ? gl_rd_q
                                                                             : fr_rd_q;
      prod_q <= x_q * y_q;
    end
    if (commit) begin
      res_line_q <= ip_d;
      res_stat_q <= res_stat_d;
      res_ereq_q <= res_ereq_d;
      res_eid_q  <= res_eid_d;
    end
    if (go_div) begin
      num_q  <= {abs_x, 8'd0};
      rem_q  <= 32'd0;
      den_q  <= abs_y;
      sign_q <= x_q[31] ^ y_q[31];
    end else if (state_q == fpss_pkg::S_DIV) begin
      num_q <= div_q;
      rem_q <= div_bit ? div_sub[31:0] : div_sh[31:0];
    end
    if (state_q == fpss_pkg::S_FIN && out_free) begin
      out_line_q <= res_line_q;
      out_stat_q <= res_stat_q;
      out_ereq_q <= res_ereq_q;
      out_eid_q  <= res_eid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpss_pkg::S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      base_q      <= FRAME_AW'(1);
      sp_q        <= FRAME_AW'(1);
      ip_q        <= '0;
      depth_q     <= '0;
      halted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fpss_pkg::S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (go_div) begin
        cnt_q <= '0;
      end else if (state_q == fpss_pkg::S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (commit) begin
        base_q   <= base_d;
        sp_q     <= sp_d;
        ip_q     <= ip_d;
        depth_q  <= depth_d;
        halted_q <= halted_d;
      end
      if (state_q == fpss_pkg::S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.next_line   = out_line_q;
  assign out_o.status      = out_stat_q;
  assign out_o.ext_request = out_ereq_q;
  assign out_o.ext_id      = out_eid_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpss_pkg::S_DIV) |-> (den_q != 32'd0))
    else $error("Divider running with a zero divisor.");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= (RET_AW+1)'(RDEPTH))
    else $error("Call depth beyond the return stack.");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == fpss_pkg::S_FIN))
    else $error("Result beat raised outside completion.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != fpss_pkg::S_IDLE))
    else $error("Accepted beat did not start work.");

endmodule

/* sim/fixed_point_stack_script_core_tb.sv */
// ----------------------------------------------------------------------------
// fixed_point_stack_script_core_tb
// Self-checking testbench for the fixed-point stack script core.
// ----------------------------------------------------------------------------
// A driver sends queued start and instruction beats in bursts with random gaps.
// An in-order predictor of the machine computes the expected result of every
// accepted beat. A monitor checks result beats against that expectation while
// the receiver stalls on its own pattern. Directed beats come first, then
// random short programs, one deep call chain and some malformed noise.
// ----------------------------------------------------------------------------
module fixed_point_stack_script_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpss_pkg::*;

  localparam int FDEPTH = 1024;
  localparam int GDEPTH = 512;
  localparam int RDEPTH = 64;
  localparam int LINES  = 4096;
  localparam int unsigned CYCLE_LIMIT = 900000;
  localparam int N_ITEMS = 1800;

  typedef struct {
    bit                 drain;
    bit                 act;
    logic [11:0]        line;
    logic [7:0]         op;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] ev;
  } instr_t;

  typedef struct {
    logic [11:0] line;
    logic [1:0]  status;
    logic        req;
    logic [23:0] id;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpss_in_if  in_bus ();
  fpss_out_if out_bus ();

  fixed_point_stack_script_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  logic [31:0] frame_mem [FDEPTH];
  logic [31:0] glob_mem [GDEPTH];
  logic [11:0] ret_mem [RDEPTH];
  int unsigned base_p, stack_p, line_p, depth;
  bit          stopped;

  instr_t  pending_q[$];
  result_t result_q[$];
  int unsigned cycles, errors, n_checked, n_starts, n_halts, n_ext;
  int burst_left, gap_left;
  bit in_took;

  function automatic int unsigned wrap_idx(longint b, longint off, longint d);
    longint r;
    r = (b + off) % d;
    if (r < 0) begin
      r += d;
    end
    return int'(r);
  endfunction

  function automatic longint sval(logic [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic result_t run_machine(instr_t it);
    result_t r;
    longint o1, o2, x, y;
    int unsigned ip, si, sj;
    r = '{line: '0, status: STAT_RUN, req: 1'b0, id: '0};
    o1 = longint'(it.a1) / 256;
    o2 = longint'(it.a2) / 256;
    if (!it.act) begin
      stopped = 0;
      base_p  = 1;
      stack_p = 1;
      depth   = 0;
      line_p  = it.line;
    end else if (stopped) begin
      r.status = STAT_DONE;
    end else begin
      ip = line_p;
      si = wrap_idx(stack_p, o1, FDEPTH);
      sj = wrap_idx(stack_p, o2, FDEPTH);
      x = sval(frame_mem[si]);
      y = sval(frame_mem[sj]);
      case (it.op)
        OP_BASE_ADD:  base_p = wrap_idx(base_p, o1, FDEPTH);
        OP_STACK_ADD: stack_p = wrap_idx(stack_p, o1, FDEPTH);
        OP_SET_B:     frame_mem[wrap_idx(base_p, o1, FDEPTH)] = it.a2;
        OP_SET_S:     frame_mem[si] = it.a2;
        OP_MOV_BI:    frame_mem[wrap_idx(base_p, x / 256, FDEPTH)] = y[31:0];
        OP_MOV_SB:    frame_mem[si] = frame_mem[wrap_idx(base_p, o2, FDEPTH)];
        OP_MOV_SS:    frame_mem[si] = y[31:0];
        OP_GSET:      glob_mem[wrap_idx(0, o1, GDEPTH)] = it.a2;
        OP_GMOV_I:    glob_mem[wrap_idx(0, x / 256, GDEPTH)] = y[31:0];
        OP_GLOAD:     frame_mem[si] = glob_mem[wrap_idx(0, o2, GDEPTH)];
        OP_GSTORE:    glob_mem[wrap_idx(0, o1, GDEPTH)] = y[31:0];
        OP_ADDC:      frame_mem[si] = 32'(x + longint'(it.a2));
        OP_ADD:       frame_mem[si] = 32'(x + y);
        OP_MUL:       frame_mem[si] = 32'((x * y) / 256);
        OP_SUB:       frame_mem[si] = 32'(x - y);
        OP_DIV: begin
          if (y == 0) begin
            stopped  = 1;
            r.status = STAT_DIV0;
          end else begin
            frame_mem[si] = 32'((x * 256) / y);
          end
        end
        OP_GLOAD_I:   frame_mem[si] = glob_mem[wrap_idx(0, y / 256, GDEPTH)];
        OP_LOAD_BI:   frame_mem[si] = frame_mem[wrap_idx(base_p, y / 256, FDEPTH)];
        OP_AND:       frame_mem[si] = x[31:0] & y[31:0];
        OP_JZ: begin
          if (frame_mem[stack_p] == 0) ip = wrap_idx(0, o1, LINES);
        end
        OP_JNZ: begin
          if (frame_mem[stack_p] != 0) ip = wrap_idx(0, o1, LINES);
        end
        OP_JMP:       ip = wrap_idx(0, o1, LINES);
        OP_EQ:        frame_mem[si] = (x == y) ? FX_ONE : 32'd0;
        OP_NE:        frame_mem[si] = (x != y) ? FX_ONE : 32'd0;
        OP_GT:        frame_mem[si] = (x > y) ? FX_ONE : 32'd0;
        OP_GE:        frame_mem[si] = (x >= y) ? FX_ONE : 32'd0;
        OP_LOR:       frame_mem[si] = (x != 0 || y != 0) ? FX_ONE : 32'd0;
        OP_LAND:      frame_mem[si] = (x != 0 && y != 0) ? FX_ONE : 32'd0;
        OP_CALL: begin
          if (depth < RDEPTH) begin
            ret_mem[depth] = ip[11:0];
            depth++;
          end
          ip = wrap_idx(0, o1, LINES);
        end
        OP_RET: begin
          if (depth == 0) begin
            stopped  = 1;
            r.status = STAT_DONE;
          end else begin
            depth--;
            ip = ret_mem[depth];
          end
        end
        OP_EXT: begin
          frame_mem[wrap_idx(base_p, -1, FDEPTH)] = it.ev;
          r.req = 1'b1;
          r.id  = o1[23:0];
        end
        default: begin
          stopped  = 1;
          r.status = STAT_BAD;
        end
      endcase
      line_p = (ip + 1) % LINES;
    end
    r.line = line_p[11:0];
    return r;
  endfunction

  function automatic void add_instr(logic [7:0] op, logic signed [31:0] a1,
                                    logic signed [31:0] a2, logic signed [31:0] ev);
    pending_q.push_back('{drain: 0, act: 1, line: $urandom, op: op, a1: a1, a2: a2, ev: ev});
  endfunction

  function automatic void add_start(logic [11:0] line);
    pending_q.push_back('{drain: 0, act: 0, line: line, op: $urandom, a1: $urandom,
                          a2: $urandom, ev: $urandom});
  endfunction

  function automatic void add_drain();
    pending_q.push_back('{drain: 1, act: 0, line: '0, op: '0, a1: '0, a2: '0, ev: '0});
  endfunction

  function automatic logic signed [31:0] rand_off();
    int off;
    if ($urandom_range(0, 15) == 0) begin
      return $urandom;
    end
    off = $urandom_range(0, 12) - 4;
    return off * 256 + (off < 0 ? -int'($urandom_range(0, 255)) : int'($urandom_range(0, 255)));
  endfunction

  function automatic logic signed [31:0] rand_const();
    if ($urandom_range(0, 1) == 0) begin
      return ($urandom_range(0, 40) - 20) * 256;
    end
    return $urandom;
  endfunction

  function automatic void add_program();
    opcode_e ops [31];
    opcode_e op;
    int len;
    ops = '{OP_BASE_ADD, OP_STACK_ADD, OP_SET_B, OP_SET_S, OP_MOV_BI, OP_MOV_SB,
            OP_MOV_SS, OP_GSET, OP_GMOV_I, OP_GLOAD, OP_GSTORE, OP_ADDC, OP_ADD,
            OP_MUL, OP_SUB, OP_DIV, OP_GLOAD_I, OP_LOAD_BI, OP_AND, OP_JZ, OP_JNZ,
            OP_JMP, OP_EQ, OP_NE, OP_GT, OP_GE, OP_LOR, OP_LAND, OP_CALL, OP_RET, OP_EXT};
    add_start($urandom);
    len = $urandom_range(1, 30);
    repeat (len) begin
      op = ops[$urandom_range(0, 30)];
      case (op)
        OP_SET_B, OP_SET_S, OP_GSET, OP_ADDC:
          add_instr(op, rand_off(), rand_const(), $urandom);
        OP_JZ, OP_JNZ, OP_JMP, OP_CALL:
          add_instr(op, $urandom_range(0, 4095) * 256 + $urandom_range(0, 255),
                    rand_off(), $urandom);
        default:
          add_instr(op, rand_off(), rand_off(), $urandom);
      endcase
    end
  endfunction

  // Input side: acceptance is seen at the rising edge, new beats go out at the falling edge.
  always @(posedge clk_i) begin
    in_took = rst_ni && in_bus.valid && in_bus.ready;
    if (in_took) begin
      result_q.push_back(run_machine('{drain: 0, act: in_bus.action,
                                       line: in_bus.start_line, op: in_bus.opcode,
                                       a1: in_bus.arg_one, a2: in_bus.arg_two,
                                       ev: in_bus.ext_value}));
      if (!in_bus.action) n_starts++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_q.size() > 0 && pending_q[0].drain) begin
        in_bus.valid <= 1'b0;
        if (result_q.size() == 0) void'(pending_q.pop_front());
      end else if (pending_q.size() > 0) begin
        instr_t it;
        it = pending_q.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.action     <= it.act;
        in_bus.start_line <= it.line;
        in_bus.opcode     <= it.op;
        in_bus.arg_one    <= it.a1;
        in_bus.arg_two    <= it.a2;
        in_bus.ext_value  <= it.ev;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    case ((cycles / 300) % 4)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= $urandom_range(0, 1);
      2: out_bus.ready <= (cycles % 5) == 0;
      default: out_bus.ready <= $urandom_range(0, 9) != 0;
    endcase
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      n_checked++;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat: line %0d status %0d",
                                   out_bus.next_line, out_bus.status);
      end else begin
        want = result_q.pop_front();
        if (out_bus.next_line !== want.line || out_bus.status !== want.status ||
            out_bus.ext_request !== want.req || out_bus.ext_id !== want.id) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch at beat %0d: expected line %0d status %0d req %0b id %0h,",
                     n_checked, want.line, want.status, want.req, want.id);
            $display("  got line %0d status %0d req %0b id %0h", out_bus.next_line,
                     out_bus.status, out_bus.ext_request, out_bus.ext_id);
          end
        end
        if (want.status == STAT_BAD || want.status == STAT_DIV0) n_halts++;
        if (want.req) n_ext++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.action = 1'b0;
    in_bus.start_line = '0;
    in_bus.opcode = '0;
    in_bus.arg_one = '0;
    in_bus.arg_two = '0;
    in_bus.ext_value = '0;
    out_bus.ready = 1'b0;
    burst_left = 1;
    gap_left = 0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (glob_mem[i]) glob_mem[i] = '0;
    foreach (ret_mem[i]) ret_mem[i] = '0;
    base_p = 1;
    stack_p = 1;
    line_p = 0;
    depth = 0;
    stopped = 1;

    // Directed beats: halted after reset, extremes, overflow, divide by zero,
    // line wrap, call and return, return with an empty call stack, bad opcode.
    add_instr(OP_ADD, 0, 0, 0);
    add_start(12'hFFF);
    add_instr(OP_SET_S, 0, 32'h7FFF_FFFF, 0);
    add_instr(OP_SET_S, 256, 32'h7FFF_FFFF, 0);
    add_instr(OP_ADD, 0, 256, 0);
    add_instr(OP_SET_S, 512, 32'h8000_0000, 0);
    add_instr(OP_MUL, 512, 256, 0);
    add_instr(OP_SUB, 256, 512, 0);
    add_instr(OP_SET_S, 768, -1, 0);
    add_instr(OP_DIV, 256, 768, 0);
    add_instr(OP_GSET, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_instr(OP_GLOAD, 1024, 32'h7FFF_FFFF, 0);
    add_instr(OP_EXT, 32'h8000_0000, 0, 32'h8000_0000);
    add_instr(OP_EXT, 32'h7FFF_FFFF, -1, 32'h7FFF_FFFF);
    add_instr(OP_JMP, -256, 0, 0);
    add_instr(OP_CALL, 100 * 256, 0, 0);
    add_instr(OP_RET, 0, 0, 0);
    add_instr(OP_JNZ, 5 * 256, 0, 0);
    add_instr(OP_JZ, 9 * 256, 0, 0);
    add_instr(OP_DIV, 0, 5 * 256, 0);
    add_instr(OP_ADD, 0, 0, 0);
    add_start(12'd0);
    add_instr(OP_RET, 0, 0, 0);
    add_start(12'd7);
    add_instr(8'hFF, -1, -1, -1);

    while (pending_q.size() < N_ITEMS) begin
      if (pending_q.size() % 450 < 30) add_drain();
      if (pending_q.size() > 800 && pending_q.size() < 830) begin
        add_start($urandom);
        repeat (RDEPTH + 2) add_instr(OP_CALL, $urandom_range(0, 4095) * 256, 0, 0);
        repeat (RDEPTH + 3) add_instr(OP_RET, $urandom, $urandom, 0);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          pending_q.push_back('{drain: 0, act: $urandom_range(0, 1), line: $urandom,
                                op: $urandom_range(0, 255), a1: $urandom, a2: $urandom,
                                ev: $urandom});
        end
      end else begin
        add_program();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() > 0 || in_bus.valid || result_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);

    $display("Checked %0d result beats from %0d start beats; %0d error halts, %0d ext calls.",
             n_checked, n_starts, n_halts, n_ext);
    if (errors == 0 && result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, result_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/fpss_pkg.sv
design/fpss_if.sv
design/fixed_point_stack_script_core.sv
sim/fixed_point_stack_script_core_tb.sv
